// ----- rtl/core/imu_stillness_gated_bias_calibrator_core_macros.svh -----
// Assertion macros for the stillness-gated bias calibrator core.
// Included by the top level; needs nothing else.
`ifndef IMU_STILLNESS_GATED_BIAS_CALIBRATOR_CORE_MACROS_SVH
`define IMU_STILLNESS_GATED_BIAS_CALIBRATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ISGBC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ISGBC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/isgbc_pkg.sv -----
// Shared types, widths, reset values and helpers for the bias calibrator.
// No dependencies; the interfaces, the divider and the top level import it.
package isgbc_pkg;

	localparam int AXES      = 6;
	localparam int GYRO_AXES = 3;
	localparam int SW        = 16;
	localparam int SUM_W     = 26;
	localparam int CNT_W     = $clog2(SUM_W);
	localparam int AXIS_W    = $clog2(AXES);
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 2;
	localparam int COUNT_W   = 8;
	localparam int GRAV_W    = 15;
	localparam int DEN_W     = 8;

	localparam logic [SW-1:0]      THRESHOLD_RST = 16'd100;
	localparam logic [COUNT_W-1:0] STILL_RST     = 8'd100;
	localparam logic [COUNT_W-1:0] AVERAGE_RST   = 8'd200;
	localparam logic [GRAV_W-1:0]  GRAVITY_RST   = 15'd8192;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hFF;

	typedef logic signed [SW-1:0] sample_t;

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_AVG  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MOTION_THRESHOLD = 2'd0,
		REG_STILL_SAMPLES    = 2'd1,
		REG_AVERAGE_SAMPLES  = 2'd2,
		REG_GRAVITY_OFFSET   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_UPDATE,
		ST_DIVIDE
	} cal_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_FIX
	} div_state_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [SW-1:0] quotient;
	} div_rsp_t;

	// One-bit full adder: {carry, sum}
	function automatic logic [1:0] fa(input logic a, input logic b, input logic c);
		logic [1:0] r;
		r = {1'b0, a} + {1'b0, b} + {1'b0, c};
		return r;
	endfunction

endpackage

// ----- rtl/core/isgbc_if.sv -----
// Handshake channels of the bias calibrator: six-axis samples in, results out.
// Depends on isgbc_pkg for the sample type.
interface isgbc_sample_if;
	import isgbc_pkg::*;
	logic    valid;
	logic    ready;
	sample_t gyro_x;
	sample_t gyro_y;
	sample_t gyro_z;
	sample_t accel_x;
	sample_t accel_y;
	sample_t accel_z;

	modport source(output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		input ready);
	modport sink(input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		output ready);
endinterface

interface isgbc_result_if;
	import isgbc_pkg::*;
	logic       valid;
	logic       ready;
	sample_t    out_gyro_x;
	sample_t    out_gyro_y;
	sample_t    out_gyro_z;
	sample_t    out_accel_x;
	sample_t    out_accel_y;
	sample_t    out_accel_z;
	logic [1:0] phase;

	modport source(output valid, out_gyro_x, out_gyro_y, out_gyro_z, out_accel_x,
		out_accel_y, out_accel_z, phase, input ready);
	modport sink(input valid, out_gyro_x, out_gyro_y, out_gyro_z, out_accel_x,
		out_accel_y, out_accel_z, phase, output ready);
endinterface

// ----- rtl/core/isgbc_div.sv -----
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on isgbc_pkg for the request and response structs.
module isgbc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  isgbc_pkg::div_req_t req,
	output isgbc_pkg::div_rsp_t rsp
);
	import isgbc_pkg::*;

	div_state_t       st_q, st_d;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic [SW-1:0]    q_lo;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign q_lo  = quo_q[SW-1:0];

	always_comb begin
		st_d = st_q;
		case (st_q)
			DV_IDLE: begin
				if (req.start)
					st_d = DV_RUN;
			end
			DV_RUN: begin
				if (cnt_q == CNT_W'(SUM_W - 1))
					st_d = DV_FIX;
			end
			DV_FIX: st_d = DV_IDLE;
			default: st_d = DV_IDLE;
		endcase
	end

	always_comb begin
		rsp.done     = 1'b0;
		rsp.quotient = q_lo;
		case (st_q)
			DV_FIX: begin
				rsp.done     = 1'b1;
				rsp.quotient = neg_q ? (~q_lo + 1'b1) : q_lo;
			end
			default: begin
				rsp.done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= DV_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == DV_RUN)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	// Work on the magnitude; apply the sign when the quotient is handed back
	always_ff @(posedge clk) begin
		if (st_q == DV_IDLE && req.start) begin
			quo_q <= req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
			neg_q <= req.dividend[SUM_W-1];
		end else if (st_q == DV_RUN) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

endmodule

// ----- rtl/core/imu_stillness_gated_bias_calibrator_core.sv -----
// Channel   | Dir | Handshake     | Payload
// sample    | in  | valid / ready | gyro_x..z, accel_x..z (signed 16 bit)
// result    | out | valid / ready | out_gyro_x..z, out_accel_x..z, phase
// wr_*      | in  | wr_en only    | wr_index (register), wr_data
//
// An item is accepted in ST_IDLE, shifted through bit-serial work in ST_SHIFT
// (the 26-bit running sums set the length), then ST_UPDATE updates state and
// loads the result. The item that ends averaging then passes through ST_DIVIDE:
// the shared divider forms the six biases one after the other.
// Reset is asynchronous and clears all control state and the biases; no sweep.
// A held result does not block acceptance; a finished item waits in its update
// cycle only while the result register is still occupied.
// Depends on isgbc_pkg, isgbc_if and isgbc_div.
`include "imu_stillness_gated_bias_calibrator_core_macros.svh"

module imu_stillness_gated_bias_calibrator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	isgbc_sample_if.sink                   sample,
	isgbc_result_if.source                 result,
	input  logic                           wr_en,
	input  logic [isgbc_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [isgbc_pkg::CFG_W-1:0]    wr_data
);
	import isgbc_pkg::*;

	// configuration
	logic [SW-1:0]      thr_q;
	logic [COUNT_W-1:0] still_lim_q;
	logic [COUNT_W-1:0] avg_lim_q;
	logic [GRAV_W-1:0]  grav_q;

	// calibration state
	cal_state_t         state_q, state_d;
	phase_t             phase_q;
	logic               have_ref_q;
	logic [COUNT_W-1:0] still_cnt_q;
	logic [COUNT_W-1:0] samp_cnt_q;
	logic [SW-1:0]      prev_q [GYRO_AXES];
	logic [SUM_W-1:0]   sum_q  [AXES];
	logic [SW-1:0]      bias_q [AXES];

	// serial datapath
	logic [CNT_W-1:0]     cnt_q;
	logic [SW-1:0]        samp_q [AXES];
	logic [SW-1:0]        res_q  [AXES];
	logic [AXES-1:0]      c_diff_q, c_sum_q;
	logic                 c_grav_q;
	logic [GYRO_AXES-1:0] c_t1_q, c_e1_q, c_t2_q, c_e2_q;
	logic [GYRO_AXES-1:0] prev_sgn_q, still_q;

	// result register
	logic          out_valid_q;
	logic [SW-1:0] out_q [AXES];
	phase_t        out_phase_q;

	// divide sequencing
	logic [AXIS_W-1:0] axis_q;
	logic              div_pend_q;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic [AXES-1:0]      s_bit, d_bit, d_cy, a_bit, a_cy;
	logic                 g_bit, g_cy, thr_bit, grav_bit;
	logic [GYRO_AXES-1:0] p_bit, t1_bit, t1_cy, e1_bit, e1_cy, t2_bit, t2_cy, e2_bit, e2_cy;
	logic [3:0]           idx;
	logic                 lo, last;
	logic [SW-1:0]        grav_ext;
	logic [SW-1:0]        samp_in [AXES];

	logic               in_acc, shift_en, out_load, out_free, div_start, last_axis;
	logic [COUNT_W-1:0] still_next, samp_next;
	logic               enter_avg, end_avg;

	assign samp_in[0] = sample.gyro_x;
	assign samp_in[1] = sample.gyro_y;
	assign samp_in[2] = sample.gyro_z;
	assign samp_in[3] = sample.accel_x;
	assign samp_in[4] = sample.accel_y;
	assign samp_in[5] = sample.accel_z;

	assign idx      = cnt_q[3:0];
	assign lo       = cnt_q < CNT_W'(SW);
	assign last     = cnt_q == CNT_W'(SUM_W - 1);
	assign grav_ext = {1'b0, grav_q};
	assign thr_bit  = lo & thr_q[idx];
	assign grav_bit = lo & grav_ext[idx];
	assign in_acc   = sample.valid & sample.ready;
	assign out_free = !out_valid_q || result.ready;
	assign last_axis = axis_q == AXIS_W'(AXES - 1);

	// One bit of every lane per cycle, LSB first; samples sign-extend as they shift
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			s_bit[i] = samp_q[i][0];
			{d_cy[i], d_bit[i]} = fa(s_bit[i], ~bias_q[i][idx], c_diff_q[i]);
			{a_cy[i], a_bit[i]} = fa(sum_q[i][0], s_bit[i], c_sum_q[i]);
		end
		{g_cy, g_bit} = fa(a_bit[AXES-1], ~grav_bit, c_grav_q);
		// delta - threshold and -delta - threshold; both negative means still
		for (int i = 0; i < GYRO_AXES; i++) begin
			p_bit[i] = lo ? prev_q[i][0] : prev_sgn_q[i];
			{t1_cy[i], t1_bit[i]} = fa(s_bit[i], ~p_bit[i], c_t1_q[i]);
			{e1_cy[i], e1_bit[i]} = fa(t1_bit[i], ~thr_bit, c_e1_q[i]);
			{t2_cy[i], t2_bit[i]} = fa(p_bit[i], ~s_bit[i], c_t2_q[i]);
			{e2_cy[i], e2_bit[i]} = fa(t2_bit[i], ~thr_bit, c_e2_q[i]);
		end
	end

	always_comb begin
		if (!have_ref_q)
			still_next = still_cnt_q;
		else if (&still_q)
			still_next = (still_cnt_q == COUNT_MAX) ? still_cnt_q : still_cnt_q + 1'b1;
		else
			still_next = '0;
		samp_next = (samp_cnt_q == COUNT_MAX) ? samp_cnt_q : samp_cnt_q + 1'b1;
		enter_avg = still_next >= still_lim_q;
		end_avg   = samp_next >= avg_lim_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample.valid)
					state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (last)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free)
					state_d = (phase_q == PH_AVG && end_avg) ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				if (div_rsp.done && last_axis)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = 1'b0;
		shift_en     = 1'b0;
		out_load     = 1'b0;
		div_start    = 1'b0;
		case (state_q)
			ST_IDLE:   sample.ready = 1'b1;
			ST_SHIFT:  shift_en     = 1'b1;
			ST_UPDATE: out_load     = out_free;
			ST_DIVIDE: div_start    = !div_pend_q;
			default: begin
				sample.ready = 1'b0;
			end
		endcase
	end

	assign div_req.start    = div_start;
	assign div_req.dividend = sum_q[axis_q];
	assign div_req.divisor  = (avg_lim_q == '0) ? DEN_W'(1) : avg_lim_q;

	isgbc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THRESHOLD_RST;
			still_lim_q <= STILL_RST;
			avg_lim_q   <= AVERAGE_RST;
			grav_q      <= GRAVITY_RST;
			state_q     <= ST_IDLE;
			phase_q     <= PH_WAIT;
			have_ref_q  <= 1'b0;
			still_cnt_q <= '0;
			samp_cnt_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			axis_q      <= '0;
			div_pend_q  <= 1'b0;
			for (int i = 0; i < GYRO_AXES; i++)
				prev_q[i] <= '0;
			for (int i = 0; i < AXES; i++) begin
				sum_q[i]  <= '0;
				bias_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					REG_MOTION_THRESHOLD: thr_q       <= wr_data[SW-1:0];
					REG_STILL_SAMPLES:    still_lim_q <= wr_data[COUNT_W-1:0];
					REG_AVERAGE_SAMPLES:  avg_lim_q   <= wr_data[COUNT_W-1:0];
					REG_GRAVITY_OFFSET:   grav_q      <= wr_data[GRAV_W-1:0];
					default: begin
						thr_q <= thr_q;
					end
				endcase
			end
			if (in_acc)
				cnt_q <= '0;
			else if (shift_en)
				cnt_q <= cnt_q + 1'b1;
			if (shift_en) begin
				// new reference shifts in as the old one shifts out
				if (lo && phase_q == PH_WAIT) begin
					for (int i = 0; i < GYRO_AXES; i++)
						prev_q[i] <= {s_bit[i], prev_q[i][SW-1:1]};
				end
				if (phase_q == PH_AVG) begin
					for (int i = 0; i < AXES - 1; i++)
						sum_q[i] <= {a_bit[i], sum_q[i][SUM_W-1:1]};
					sum_q[AXES-1] <= {g_bit, sum_q[AXES-1][SUM_W-1:1]};
				end
			end
			if (out_load) begin
				case (phase_q)
					PH_WAIT: begin
						still_cnt_q <= still_next;
						have_ref_q  <= 1'b1;
						if (enter_avg)
							phase_q <= PH_AVG;
					end
					PH_AVG: begin
						samp_cnt_q <= samp_next;
						if (end_avg)
							phase_q <= PH_DONE;
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			if (div_start)
				div_pend_q <= 1'b1;
			if (div_rsp.done) begin
				div_pend_q     <= 1'b0;
				bias_q[axis_q] <= div_rsp.quotient;
				axis_q         <= last_axis ? '0 : axis_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < AXES; i++)
				samp_q[i] <= samp_in[i];
			c_diff_q <= '1;
			c_sum_q  <= '0;
			c_grav_q <= 1'b1;
			c_t1_q   <= '1;
			c_e1_q   <= '1;
			c_t2_q   <= '1;
			c_e2_q   <= '1;
			for (int i = 0; i < GYRO_AXES; i++)
				prev_sgn_q[i] <= prev_q[i][SW-1];
		end else if (shift_en) begin
			for (int i = 0; i < AXES; i++) begin
				samp_q[i] <= {samp_q[i][SW-1], samp_q[i][SW-1:1]};
				if (lo)
					res_q[i] <= {d_bit[i], res_q[i][SW-1:1]};
			end
			c_diff_q <= d_cy;
			c_sum_q  <= a_cy;
			c_grav_q <= g_cy;
			c_t1_q   <= t1_cy;
			c_e1_q   <= e1_cy;
			c_t2_q   <= t2_cy;
			c_e2_q   <= e2_cy;
			if (last)
				still_q <= e1_bit & e2_bit;
		end
		if (out_load) begin
			for (int i = 0; i < AXES; i++)
				out_q[i] <= res_q[i];
			out_phase_q <= phase_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_gyro_x  = out_q[0];
	assign result.out_gyro_y  = out_q[1];
	assign result.out_gyro_z  = out_q[2];
	assign result.out_accel_x = out_q[3];
	assign result.out_accel_y = out_q[4];
	assign result.out_accel_z = out_q[5];
	assign result.phase       = out_phase_q;

	`ISGBC_ASSERT_NEXT(a_done_sticks, clk, arst_n, phase_q == PH_DONE, phase_q == PH_DONE, "calibrated phase left")
	`ISGBC_ASSERT_IMPL(a_divide_after_avg, clk, arst_n, state_q == ST_DIVIDE, phase_q == PH_DONE, "divide outside calibrated phase")
	`ISGBC_ASSERT_IMPL(a_div_rsp_expected, clk, arst_n, div_rsp.done, state_q == ST_DIVIDE && div_pend_q, "unexpected quotient")
	`ISGBC_ASSERT_IMPL(a_no_accept_while_dividing, clk, arst_n, sample.ready, !div_pend_q, "sample taken during divide")

endmodule
